FILE: sv/audio_level_classifier_core_defines.svh
// Assertion macros of the audio level classifier RTL, used by the sequencer alc_ctrl.
`ifndef AUDIO_LEVEL_CLASSIFIER_CORE_DEFINES_SVH
`define AUDIO_LEVEL_CLASSIFIER_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define ALC_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("alc assertion failed");

// next-cycle implication, checked outside reset
`define ALC_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("alc assertion failed");

`endif

FILE: sv/alc_pkg.sv
// Types and constants of the audio level classifier.
package alc_pkg;

	localparam int unsigned SAMPLE_W  = 24;
	localparam int unsigned DC_W      = 25;
	localparam int unsigned SUM_W     = 32;
	localparam int unsigned CNT_W     = 13;
	localparam int unsigned LEVEL_W   = 24;
	localparam int unsigned CLASS_W   = 3;
	localparam int unsigned RUN_W     = 3;
	localparam int unsigned DIV_STEPS = SUM_W;
	localparam int unsigned STEP_W    = $clog2(DIV_STEPS);

	localparam logic [LEVEL_W-1:0] RISE_STEP      = LEVEL_W'(5000);
	localparam logic [RUN_W-1:0]   RUN_FOR_SUDDEN = RUN_W'(5);

	localparam logic [LEVEL_W-1:0] CALM_RST  = LEVEL_W'(200);
	localparam logic [LEVEL_W-1:0] HUMAN_RST = LEVEL_W'(800);
	localparam logic [LEVEL_W-1:0] LOUD_RST  = LEVEL_W'(2000);
	localparam logic [LEVEL_W-1:0] CLAP_RST  = LEVEL_W'(4000);

	typedef enum logic [1:0] {
		REG_CALM  = 2'd0,
		REG_HUMAN = 2'd1,
		REG_LOUD  = 2'd2,
		REG_CLAP  = 2'd3
	} cfg_reg_t;

	typedef enum logic [CLASS_W-1:0] {
		CLS_CALM   = 3'd0,
		CLS_MUSIC  = 3'd1,
		CLS_HUMAN  = 3'd2,
		CLS_NOISY  = 3'd3,
		CLS_SUDDEN = 3'd4
	} env_class_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_DONE
	} ctl_state_t;

	typedef struct packed {
		logic accept;
		logic div_step;
		logic load_out;
	} dp_cmd_t;

	typedef struct packed {
		logic frame_close;
		logic div_last;
	} dp_sts_t;

endpackage

FILE: sv/alc_ctrl.sv
// Sequencer of the audio level classifier: request handshake and divider control.
module alc_ctrl
	import alc_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	output logic    out_valid,
	input  logic    out_ready,
	output dp_cmd_t cmd,
	input  dp_sts_t sts
);

	`include "audio_level_classifier_core_defines.svh"

	ctl_state_t state_q, state_nx;
	logic       out_valid_q;

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid && sts.frame_close) begin
					state_nx = ST_DIV;
				end
			end
			ST_DIV: begin
				if (sts.div_last) begin
					state_nx = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					state_nx = ST_IDLE;
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready     = 1'b0;
		cmd.accept   = 1'b0;
		cmd.div_step = 1'b0;
		cmd.load_out = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
			end
			ST_DONE: begin
				cmd.load_out = !out_valid_q || out_ready;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	`ALC_ASSERT_NXT(a_close_starts_div, cmd.accept && sts.frame_close, state_q == ST_DIV)
	`ALC_ASSERT_NXT(a_last_step_done, state_q == ST_DIV && sts.div_last, state_q == ST_DONE)
	`ALC_ASSERT_NXT(a_load_shows_result, cmd.load_out, out_valid_q)
	`ALC_ASSERT_NOW(a_no_accept_busy, state_q != ST_IDLE, !cmd.accept)

endmodule

FILE: sv/alc_dp.sv
// Datapath of the audio level classifier: DC removal, frame sum, divider, classifier.
module alc_dp
	import alc_pkg::*;
#(
	parameter int unsigned FRAME_DEPTH = 256
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_addr,
	input  logic [LEVEL_W-1:0]  cfg_wdata,
	input  logic signed [31:0]  raw_word,
	input  logic                frame_end,
	input  dp_cmd_t             cmd,
	output dp_sts_t             sts,
	output logic [LEVEL_W-1:0]  level,
	output logic [CLASS_W-1:0]  env_class
);

	logic [LEVEL_W-1:0] calm_q, human_q, loud_q, clap_q;

	logic signed [DC_W-1:0]  dc_q;
	logic [SUM_W-1:0]        sum_q;
	logic [CNT_W-1:0]        cnt_q;
	logic [SUM_W-1:0]        sm_q;
	logic [LEVEL_W-1:0]      prev_q;
	logic [RUN_W-1:0]        run_q;

	logic [SUM_W-1:0]        quo_q;
	logic [CNT_W-1:0]        rem_q;
	logic [CNT_W-1:0]        dvs_q;
	logic [STEP_W-1:0]       step_q;

	logic [LEVEL_W-1:0]      level_q;
	env_class_t              class_q;

	logic signed [SAMPLE_W-1:0] x;
	logic signed [35:0]         dc_acc;
	logic signed [DC_W-1:0]     dc_nx;
	logic signed [DC_W:0]       resid;
	logic [DC_W:0]              mag;
	logic [SUM_W:0]             sum_wide;
	logic [SUM_W-1:0]           sum_sat;
	logic [CNT_W-1:0]           cnt_inc;
	logic [SUM_W+1:0]           sm_wide;
	logic [SUM_W-1:0]           sm_nx;

	logic [CNT_W:0]             rem_sh;
	logic                       rem_ge;

	logic [LEVEL_W-1:0]         e;
	logic                       rise;
	logic [RUN_W-1:0]           run_inc;
	logic [RUN_W-1:0]           run_nx;
	env_class_t                 cls;

	// sample path
	assign x        = $signed(raw_word[31:8]);
	assign dc_acc   = (36'(dc_q) <<< 10) - 36'(dc_q) + 36'(x);
	assign dc_nx    = DC_W'(dc_acc >>> 10);
	assign resid    = (DC_W+1)'(x) - (DC_W+1)'(dc_nx);
	assign mag      = resid[DC_W] ? (DC_W+1)'(-resid) : (DC_W+1)'(resid);
	assign sum_wide = {1'b0, sum_q} + (SUM_W+1)'(mag);
	assign sum_sat  = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
	assign cnt_inc  = cnt_q + CNT_W'(1);
	assign sm_wide  = ({2'b00, sm_q} << 1) + {2'b00, sm_q} + {2'b00, sum_sat};
	assign sm_nx    = sm_wide[SUM_W+1:2];

	assign sts.frame_close = frame_end || (cnt_inc >= CNT_W'(FRAME_DEPTH));

	// restoring divider, one quotient bit a cycle
	assign rem_sh       = {rem_q, quo_q[SUM_W-1]};
	assign rem_ge       = rem_sh >= {1'b0, dvs_q};
	assign sts.div_last = (step_q == STEP_W'(DIV_STEPS - 1));

	// level and classification
	assign e       = (quo_q[SUM_W-1:LEVEL_W] != '0) ? '1 : quo_q[LEVEL_W-1:0];
	assign rise    = (e > clap_q) && (e > prev_q) && ((e - prev_q) > RISE_STEP);
	assign run_inc = rise ? run_q + RUN_W'(1) : '0;

	always_comb begin
		run_nx = run_inc;
		if (run_inc >= RUN_FOR_SUDDEN) begin
			run_nx = '0;
			cls    = CLS_SUDDEN;
		end else if (e > loud_q) begin
			cls = CLS_NOISY;
		end else if (e > human_q) begin
			cls = CLS_HUMAN;
		end else if (e > calm_q) begin
			cls = CLS_MUSIC;
		end else begin
			cls = CLS_CALM;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			calm_q  <= CALM_RST;
			human_q <= HUMAN_RST;
			loud_q  <= LOUD_RST;
			clap_q  <= CLAP_RST;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_addr))
				REG_CALM:  calm_q  <= cfg_wdata;
				REG_HUMAN: human_q <= cfg_wdata;
				REG_LOUD:  loud_q  <= cfg_wdata;
				REG_CLAP:  clap_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dc_q   <= '0;
			sum_q  <= '0;
			cnt_q  <= '0;
			sm_q   <= '0;
			prev_q <= '0;
			run_q  <= '0;
		end else begin
			if (cmd.accept) begin
				dc_q <= dc_nx;
				if (sts.frame_close) begin
					sum_q <= '0;
					cnt_q <= '0;
					sm_q  <= sm_nx;
				end else begin
					sum_q <= sum_sat;
					cnt_q <= cnt_inc;
				end
			end
			if (cmd.load_out) begin
				prev_q <= e;
				run_q  <= run_nx;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept && sts.frame_close) begin
			quo_q  <= sm_nx;
			rem_q  <= '0;
			dvs_q  <= cnt_inc;
			step_q <= '0;
		end else if (cmd.div_step) begin
			quo_q  <= {quo_q[SUM_W-2:0], rem_ge};
			rem_q  <= rem_ge ? CNT_W'(rem_sh - {1'b0, dvs_q}) : CNT_W'(rem_sh);
			step_q <= step_q + STEP_W'(1);
		end
		if (cmd.load_out) begin
			level_q <= e;
			class_q <= cls;
		end
	end

	assign level     = level_q;
	assign env_class = class_q;

endmodule

FILE: sv/audio_level_classifier_core.sv
// Top level of the audio level classifier: DC-blocked smoothed mean absolute level per frame.
//
// Input requests carry one raw microphone word (upper 24 bits used) and a frame_end
// flag. Samples inside a frame are taken one per cycle. A sample with frame_end set,
// or the FRAME_DEPTH-th sample of a frame, closes the frame: the smoothed sum is then
// divided by the sample count in a restoring divider, one quotient bit per cycle,
// so the closing sample is followed by the divide steps of ST_DIV and the load in ST_DONE.
// in_ready is low in ST_DIV and ST_DONE; the result (level, env_class) is loaded into the
// output register in ST_DONE once the output slot is free.
// A frame costs its samples plus the divide and the load; the divider sets the overhead.
// One result request is produced per frame, none for other samples.
// If the receiver stalls, the result is held in the output register and samples of
// the next frame are still taken; only the next result waits in ST_DONE for the slot.
// Configuration writes (calm, human, loud, clap thresholds) take effect at once;
// the user must make them while the block is idle; the block does not enforce it.
// Reset clears the DC estimate, frame sum, count, smoothed sum, rise history and
// restores the threshold defaults; the output channel is empty after reset.
module audio_level_classifier_core
	import alc_pkg::*;
#(
	parameter int unsigned FRAME_DEPTH = 256
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_addr,
	input  logic [LEVEL_W-1:0]  cfg_wdata,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic signed [31:0]  raw_word,
	input  logic                frame_end,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [LEVEL_W-1:0]  level,
	output logic [CLASS_W-1:0]  env_class
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	alc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	alc_dp #(
		.FRAME_DEPTH (FRAME_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.raw_word  (raw_word),
		.frame_end (frame_end),
		.cmd       (cmd),
		.sts       (sts),
		.level     (level),
		.env_class (env_class)
	);

endmodule
